@@ hw/rtl/ffes_pkg.sv @@
// Package for the flash EEPROM emulation store: payload structs,
// request and status codes and fixed constants. No dependencies.
`timescale 1ns / 1ps

package ffes_pkg;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] data_word;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_word;
        logic        last;
        logic        record_done;
    } t_out_item;

    localparam logic [1:0] REQ_INIT  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_INIT  = 2'd1;
    localparam logic [1:0] ST_NO_RECORD = 2'd2;

    localparam logic [31:0] BLANK_WORD = 32'hFFFF_FFFF;
    localparam logic [5:0]  RECORD_WORDS_RESET = 6'd32;
    localparam logic [5:0]  CNT_SAT = 6'd63;
    localparam int          MAX_OUT = 32;

endpackage

@@ hw/rtl/flash_eeprom_emulation_store.sv @@
// Flash EEPROM emulation store, top level. Uses ffes_pkg and ffes_ram.
// Page metadata in registers, record words in one RAM.
//
// Emulates an EEPROM record on two flash pages, each of BLOCKS_PER_PAGE blocks
// of BLOCK_WORDS words, with page counts, erase marks and per-block start and
// end marks. Requests: init (repair blank pages, pick the page with the larger
// count, abandon an open write), write one record word, read the newest
// completed record, and a no-op. An input transfer is taken whenever the
// sequencer is idle, even while the previous result still waits at the output
// register. Init, write, no-op and rejected requests give one result. A read
// gives one result per word of record_words clamped to 1 .. min(BLOCK_WORDS,
// 32); for each word an address state starts the registered read of the
// record RAM and a data state passes the word to the output register. No new
// input is taken until a read is through. Output stalls hold the sequencer.
// Block state is kept as per-page fill counts and a newest-completed index,
// so no clearing pass runs after reset.
`timescale 1ns / 1ps

module flash_eeprom_emulation_store
    import ffes_pkg::*;
#(
    parameter int BLOCKS_PER_PAGE = 6,
    parameter int BLOCK_WORDS     = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [5:0] i_cfg_data
);

    localparam int BW_B    = (BLOCKS_PER_PAGE > 1) ? $clog2(BLOCKS_PER_PAGE) : 1;
    localparam int CW      = $clog2(BLOCKS_PER_PAGE + 1);
    localparam int DEPTH   = 2 * BLOCKS_PER_PAGE * BLOCK_WORDS;
    localparam int AW      = $clog2(DEPTH);
    localparam int LEN_MAX = (BLOCK_WORDS < MAX_OUT) ? BLOCK_WORDS : MAX_OUT;
    localparam logic [5:0]    LEN_MAX_W = 6'(LEN_MAX);
    localparam logic [CW-1:0] BPP_C     = CW'(BLOCKS_PER_PAGE);
    localparam logic [6:0]    BW_C      = 7'(BLOCK_WORDS);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_RADDR, S_RDATA} t_state;

    t_state         r_state, n_state;
    t_in_item       r_req, n_req;
    t_out_item      r_out, n_out;
    logic           r_out_valid, n_out_valid;
    logic [5:0]     r_record_words, n_record_words;
    logic [1:0]     r_erase_mark, n_erase_mark;
    logic [31:0]    r_gen [2];
    logic [31:0]    n_gen [2];
    logic [CW-1:0]  r_start_cnt [2];
    logic [CW-1:0]  n_start_cnt [2];
    logic [1:0]     r_has_done, n_has_done;
    logic [BW_B-1:0] r_done_blk [2];
    logic [BW_B-1:0] n_done_blk [2];
    logic           r_active, n_active;
    logic           r_init, n_init;
    logic           r_wopen, n_wopen;
    logic           r_tpage, n_tpage;
    logic [BW_B-1:0] r_tblk, n_tblk;
    logic [5:0]     r_wcnt, n_wcnt;
    logic [5:0]     r_rd_cnt, n_rd_cnt;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [31:0]    ram_rdata;
    logic [5:0]     len;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // record length clamped to 1 .. min(BLOCK_WORDS, 32)
    always_comb begin
        if (r_record_words == 6'd0) begin
            len = 6'd1;
        end else if (r_record_words > LEN_MAX_W) begin
            len = LEN_MAX_W;
        end else begin
            len = r_record_words;
        end
    end

    assign ram_raddr = AW'((int'(r_active) * BLOCKS_PER_PAGE + int'(r_done_blk[r_active]))
                           * BLOCK_WORDS + int'(r_rd_cnt));

    always_comb begin
        logic            out_free;
        logic            found;
        logic            cur_page;
        logic [BW_B-1:0] cur_blk;
        logic [5:0]      cur_cnt;
        logic [5:0]      cnt_nx;
        logic [31:0]     g0;
        logic [31:0]     g1;

        n_state        = r_state;
        n_req          = r_req;
        n_out          = r_out;
        n_out_valid    = r_out_valid;
        n_record_words = r_record_words;
        n_erase_mark   = r_erase_mark;
        n_gen          = r_gen;
        n_start_cnt    = r_start_cnt;
        n_has_done     = r_has_done;
        n_done_blk     = r_done_blk;
        n_active       = r_active;
        n_init         = r_init;
        n_wopen        = r_wopen;
        n_tpage        = r_tpage;
        n_tblk         = r_tblk;
        n_wcnt         = r_wcnt;
        n_rd_cnt       = r_rd_cnt;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_re         = 1'b0;
        found          = 1'b0;
        cur_page       = r_tpage;
        cur_blk        = r_tblk;
        cur_cnt        = r_wcnt;
        cnt_nx         = r_wcnt;
        g0             = r_gen[0];
        g1             = r_gen[1];

        out_free = !r_out_valid || i_out_ready;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            n_record_words = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_out.status      = ST_OK;
                    n_out.read_word   = '0;
                    n_out.last        = 1'b1;
                    n_out.record_done = 1'b0;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                    if (r_req.req_type == REQ_INIT) begin
                        n_wopen = 1'b0;
                        for (int p = 0; p < 2; p++) begin
                            if (!r_erase_mark[p]) begin
                                n_start_cnt[p]  = '0;
                                n_has_done[p]   = 1'b0;
                                n_erase_mark[p] = 1'b1;
                            end
                        end
                        g0 = r_erase_mark[0] ? r_gen[0] : BLANK_WORD;
                        g1 = r_erase_mark[1] ? r_gen[1] : BLANK_WORD;
                        if (g0 == BLANK_WORD) g0 = 32'd0;
                        if (g1 == BLANK_WORD) g1 = 32'd1;
                        n_gen[0] = g0;
                        n_gen[1] = g1;
                        n_active = (g0 > g1) ? 1'b0 : 1'b1;
                        n_init   = 1'b1;
                    end else if (r_req.req_type == REQ_NONE) begin
                        n_out.status = ST_OK;
                    end else if (!r_init) begin
                        n_out.status = ST_NOT_INIT;
                    end else if (r_req.req_type == REQ_WRITE) begin
                        if (!r_wopen) begin
                            found = r_start_cnt[r_active] < BPP_C;
                            if (found) begin
                                cur_page = r_active;
                                cur_blk  = BW_B'(r_start_cnt[r_active]);
                            end else begin
                                // active page full: erase the other page, use block 0
                                cur_page = !r_active;
                                cur_blk  = '0;
                                n_has_done[cur_page]   = 1'b0;
                                n_gen[cur_page]        = BLANK_WORD;
                                n_erase_mark[cur_page] = 1'b1;
                            end
                            n_start_cnt[cur_page] = CW'(cur_blk) + CW'(1);
                            cur_cnt = 6'd0;
                        end
                        n_tpage = cur_page;
                        n_tblk  = cur_blk;
                        if ({1'b0, cur_cnt} < BW_C) begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'((int'(cur_page) * BLOCKS_PER_PAGE + int'(cur_blk))
                                            * BLOCK_WORDS + int'(cur_cnt));
                        end
                        cnt_nx = (cur_cnt < CNT_SAT) ? cur_cnt + 6'd1 : cur_cnt;
                        n_wcnt = cnt_nx;
                        if (cnt_nx >= len) begin
                            n_has_done[cur_page] = 1'b1;
                            n_done_blk[cur_page] = cur_blk;
                            if (cur_page != r_active) begin
                                n_gen[cur_page] = r_gen[r_active] + 32'd1;
                                n_active        = cur_page;
                            end
                            n_wopen           = 1'b0;
                            n_out.record_done = 1'b1;
                        end else begin
                            n_wopen = 1'b1;
                        end
                    end else begin
                        if (r_has_done[r_active]) begin
                            n_out_valid = r_out_valid && !i_out_ready;
                            n_rd_cnt    = 6'd0;
                            n_state     = S_RADDR;
                        end else begin
                            n_out.status = ST_NO_RECORD;
                        end
                    end
                end
            end
            S_RADDR: begin
                ram_re  = 1'b1;
                n_state = S_RDATA;
            end
            S_RDATA: begin
                if (out_free) begin
                    n_out.status      = ST_OK;
                    n_out.read_word   = ram_rdata;
                    n_out.last        = (r_rd_cnt + 6'd1) == len;
                    n_out.record_done = 1'b0;
                    n_out_valid       = 1'b1;
                    if ((r_rd_cnt + 6'd1) == len) begin
                        n_state = S_IDLE;
                    end else begin
                        n_rd_cnt = r_rd_cnt + 6'd1;
                        n_state  = S_RADDR;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_record_words <= RECORD_WORDS_RESET;
            r_erase_mark   <= '0;
            r_gen[0]       <= BLANK_WORD;
            r_gen[1]       <= BLANK_WORD;
            r_start_cnt[0] <= '0;
            r_start_cnt[1] <= '0;
            r_has_done     <= '0;
            r_active       <= 1'b0;
            r_init         <= 1'b0;
            r_wopen        <= 1'b0;
            r_tpage        <= 1'b0;
            r_tblk         <= '0;
            r_wcnt         <= '0;
            r_rd_cnt       <= '0;
        end else begin
            r_state        <= n_state;
            r_out_valid    <= n_out_valid;
            r_record_words <= n_record_words;
            r_erase_mark   <= n_erase_mark;
            r_gen          <= n_gen;
            r_start_cnt    <= n_start_cnt;
            r_has_done     <= n_has_done;
            r_active       <= n_active;
            r_init         <= n_init;
            r_wopen        <= n_wopen;
            r_tpage        <= n_tpage;
            r_tblk         <= n_tblk;
            r_wcnt         <= n_wcnt;
            r_rd_cnt       <= n_rd_cnt;
        end
        r_req      <= n_req;
        r_out      <= n_out;
        r_done_blk <= n_done_blk;
    end

    ffes_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_record_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ram_we),
        .i_wr_addr(ram_waddr),
        .i_wr_data(r_req.data_word),
        .i_rd_en  (ram_re),
        .i_rd_addr(ram_raddr),
        .o_rd_data(ram_rdata)
    );

endmodule

@@ hw/rtl/ffes_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ffes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 384,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sim/flash_eeprom_emulation_store_tb.sv @@
// Self-checking testbench for flash_eeprom_emulation_store: directed and random
// requests, a shadow model of both flash pages and per-field result checks.
// Depends on ffes_pkg and the store RTL only.
`timescale 1ns / 1ps

module flash_eeprom_emulation_store_tb;
    import ffes_pkg::*;

    localparam int PAGE_BLOCKS     = 6;
    localparam int WORDS_PER_BLOCK = 32;
    localparam int SLOTS           = 2 * PAGE_BLOCKS;
    localparam int FLASH_DEPTH     = SLOTS * WORDS_PER_BLOCK;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 5000;
    localparam int RANDOM_ITEMS    = 130;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [5:0] i_cfg_data;

    flash_eeprom_emulation_store #(
        .BLOCKS_PER_PAGE (PAGE_BLOCKS),
        .BLOCK_WORDS     (WORDS_PER_BLOCK)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow copy of the flash pages and the write sequencer
    logic [5:0]  len_setting;
    bit          page_marked [2];
    bit          blk_begun [SLOTS];
    bit          blk_closed [SLOTS];
    logic [31:0] page_count [2];
    logic [31:0] flash_words [FLASH_DEPTH];
    bit          word_written [FLASH_DEPTH];
    bit          cur_page;
    bit          store_ready;
    bit          rec_in_progress;
    bit          wr_page;
    int          wr_block;
    int          wr_count;

    t_out_item   awaited_responses [$];
    int          mismatches = 0;
    int          idle_pct   = 30;
    int          hold_left  = 0;
    int          quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int record_len();
        int n;
        n = len_setting;
        if (n < 1) n = 1;
        if (n > WORDS_PER_BLOCK) n = WORDS_PER_BLOCK;
        if (n > MAX_OUT) n = MAX_OUT;
        return n;
    endfunction

    function automatic void wipe_page(int p);
        for (int b = 0; b < PAGE_BLOCKS; b++) begin
            blk_begun[p * PAGE_BLOCKS + b]  = 1'b0;
            blk_closed[p * PAGE_BLOCKS + b] = 1'b0;
        end
        for (int w = 0; w < PAGE_BLOCKS * WORDS_PER_BLOCK; w++) begin
            flash_words[p * PAGE_BLOCKS * WORDS_PER_BLOCK + w]  = '0;
            word_written[p * PAGE_BLOCKS * WORDS_PER_BLOCK + w] = 1'b0;
        end
        page_count[p]  = BLANK_WORD;
        page_marked[p] = 1'b1;
    endfunction

    function automatic void clear_shadow();
        len_setting = RECORD_WORDS_RESET;
        for (int p = 0; p < 2; p++) begin
            page_marked[p] = 1'b0;
            page_count[p]  = BLANK_WORD;
        end
        for (int s = 0; s < SLOTS; s++) begin
            blk_begun[s]  = 1'b0;
            blk_closed[s] = 1'b0;
        end
        for (int w = 0; w < FLASH_DEPTH; w++) begin
            flash_words[w]  = '0;
            word_written[w] = 1'b0;
        end
        cur_page        = 1'b0;
        store_ready     = 1'b0;
        rec_in_progress = 1'b0;
        wr_page         = 1'b0;
        wr_block        = 0;
        wr_count        = 0;
    endfunction

    function automatic t_out_item response(logic [1:0] st, logic [31:0] word,
                                           logic is_last, logic done);
        t_out_item r;
        r.status      = st;
        r.read_word   = word;
        r.last        = is_last;
        r.record_done = done;
        return r;
    endfunction

    function automatic int newest_closed();
        for (int b = PAGE_BLOCKS - 1; b >= 0; b--)
            if (blk_closed[int'(cur_page) * PAGE_BLOCKS + b])
                return int'(cur_page) * PAGE_BLOCKS + b;
        return -1;
    endfunction

    // a read must only touch record words written since the last erase
    function automatic bit read_is_covered();
        int slot;
        int n;
        slot = newest_closed();
        n    = record_len();
        if (slot < 0) return 1'b1;
        for (int k = 0; k < n; k++)
            if (!word_written[slot * WORDS_PER_BLOCK + k]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void compute_responses(t_in_item req);
        int len;
        int slot;
        int b;
        bit done;
        len = record_len();
        if (req.req_type == REQ_INIT) begin
            rec_in_progress = 1'b0;
            for (int p = 0; p < 2; p++)
                if (!page_marked[p]) wipe_page(p);
            if (page_count[0] == BLANK_WORD) page_count[0] = 32'd0;
            if (page_count[1] == BLANK_WORD) page_count[1] = 32'd1;
            cur_page    = (page_count[0] > page_count[1]) ? 1'b0 : 1'b1;
            store_ready = 1'b1;
            awaited_responses.push_back(response(ST_OK, '0, 1'b1, 1'b0));
        end else if (req.req_type == REQ_NONE) begin
            awaited_responses.push_back(response(ST_OK, '0, 1'b1, 1'b0));
        end else if (!store_ready) begin
            awaited_responses.push_back(response(ST_NOT_INIT, '0, 1'b1, 1'b0));
        end else if (req.req_type == REQ_WRITE) begin
            if (!rec_in_progress) begin
                b = 0;
                while (b < PAGE_BLOCKS && blk_begun[int'(cur_page) * PAGE_BLOCKS + b])
                    b++;
                if (b < PAGE_BLOCKS) begin
                    wr_page  = cur_page;
                    wr_block = b;
                end else begin
                    // active page full: erase the other page and start over there
                    wr_page  = ~cur_page;
                    wr_block = 0;
                    wipe_page(int'(wr_page));
                end
                blk_begun[int'(wr_page) * PAGE_BLOCKS + wr_block] = 1'b1;
                wr_count        = 0;
                rec_in_progress = 1'b1;
            end
            slot = int'(wr_page) * PAGE_BLOCKS + wr_block;
            if (wr_count < WORDS_PER_BLOCK) begin
                flash_words[slot * WORDS_PER_BLOCK + wr_count]  = req.data_word;
                word_written[slot * WORDS_PER_BLOCK + wr_count] = 1'b1;
            end
            if (wr_count < int'(CNT_SAT)) wr_count++;
            done = 1'b0;
            if (wr_count >= len) begin
                blk_closed[slot] = 1'b1;
                if (wr_page != cur_page) begin
                    page_count[wr_page] = page_count[cur_page] + 32'd1;
                    cur_page            = wr_page;
                end
                rec_in_progress = 1'b0;
                done            = 1'b1;
            end
            awaited_responses.push_back(response(ST_OK, '0, 1'b1, done));
        end else begin
            slot = newest_closed();
            if (slot < 0) begin
                awaited_responses.push_back(response(ST_NO_RECORD, '0, 1'b1, 1'b0));
            end else begin
                for (int k = 0; k < len; k++)
                    awaited_responses.push_back(response(ST_OK,
                        flash_words[slot * WORDS_PER_BLOCK + k], k == len - 1, 1'b0));
            end
        end
    endfunction

    function automatic t_in_item make_req(logic [1:0] kind, logic [31:0] word);
        t_in_item it;
        it.req_type  = kind;
        it.data_word = word;
        return it;
    endfunction

    function automatic t_in_item next_random_request();
        t_in_item it;
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) it.data_word = '0;
        else if (r < 20) it.data_word = BLANK_WORD;
        else it.data_word = $urandom;
        r = $urandom_range(0, 99);
        if (r < 72) it.req_type = REQ_WRITE;
        else if (r < 88) it.req_type = read_is_covered() ? REQ_READ : REQ_WRITE;
        else if (r < 94) it.req_type = REQ_INIT;
        else it.req_type = REQ_NONE;
        return it;
    endfunction

    task automatic check_response(t_out_item got);
        t_out_item want;
        if (awaited_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: status=%0d word=%h last=%0b done=%0b",
                         got.status, got.read_word, got.last, got.record_done);
            return;
        end
        want = awaited_responses.pop_front();
        if (got.status !== want.status || got.read_word !== want.read_word ||
            got.last !== want.last || got.record_done !== want.record_done) begin
            mismatches++;
            if (mismatches <= 10) begin
                $write("result mismatch: expected status=%0d word=%h last=%0b done=%0b,",
                       want.status, want.read_word, want.last, want.record_done);
                $display(" got status=%0d word=%h last=%0b done=%0b",
                         got.status, got.read_word, got.last, got.record_done);
            end
        end
    endtask

    task automatic send_item(t_in_item item);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        compute_responses(item);
    endtask

    // drop valid, wait for every awaited result, then give the block time to go idle
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_responses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_length(logic [5:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        len_setting = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_before_init();
        send_item(make_req(REQ_WRITE, 32'hA5A5_A5A5));
        send_item(make_req(REQ_READ, '0));
        send_item(make_req(REQ_NONE, BLANK_WORD));
        settle();
    endtask

    task automatic test_init_empty_read();
        send_item(make_req(REQ_INIT, BLANK_WORD));
        send_item(make_req(REQ_READ, '0));
        send_item(make_req(REQ_NONE, '0));
        settle();
    endtask

    // shrink the length while a record is open: the next word commits it
    task automatic test_length_change();
        program_length(6'd63);
        send_item(make_req(REQ_WRITE, '0));
        send_item(make_req(REQ_WRITE, BLANK_WORD));
        settle();
        program_length(6'd0);
        send_item(make_req(REQ_WRITE, 32'hA5A5_A5A5));
        send_item(make_req(REQ_READ, '0));
        settle();
    endtask

    task automatic test_page_rollover();
        program_length(6'd1);
        repeat (6) send_item(make_req(REQ_WRITE, $urandom));
        send_item(make_req(REQ_READ, '0));
        settle();
    endtask

    // init in the middle of a record models power loss
    task automatic test_abandoned_write();
        program_length(6'd3);
        repeat (4) send_item(make_req(REQ_WRITE, $urandom));
        send_item(make_req(REQ_INIT, '0));
        send_item(make_req(REQ_READ, '0));
        settle();
    endtask

    task automatic test_output_stall();
        program_length(6'd2);
        idle_pct  = 0;
        hold_left = HOLD_CYCLES;
        repeat (20) send_item(next_random_request());
        settle();
        idle_pct = 30;
    endtask

    task automatic test_random_traffic();
        int sent;
        int phase;
        int count;
        int r;
        logic [5:0] len_pick;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 65) len_pick = 6'($urandom_range(1, 5));
            else if (r < 75) len_pick = 6'd0;
            else len_pick = 6'($urandom_range(6, 63));
            program_length(len_pick);
            idle_pct = (phase == 1) ? 0 : 30;
            count    = (len_pick > 6'd8) ? 40 : 24;
            repeat (count) send_item(next_random_request());
            settle();
            sent += count;
            phase++;
        end
        idle_pct = 30;
    endtask

    // receiver: random ready, long hold-off on request, checks every transfer
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) check_response(o_out_data);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        clear_shadow();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_before_init();
        test_init_empty_read();
        test_length_change();
        test_page_rollover();
        test_abandoned_write();
        test_output_stall();
        test_random_traffic();

        settle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && awaited_responses.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
